>>> hw/rtl/ttlst_pkg.sv
// Shared constants, codes and controller/datapath interface types for the subscription table.
package ttlst_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [13:0] TPS_RESET = 14'd1000;

   typedef enum logic [2:0] {
      ACT_SUBSCRIBE   = 3'd0,
      ACT_UNSUBSCRIBE = 3'd1,
      ACT_QUERY       = 3'd2,
      ACT_SWEEP       = 3'd3,
      ACT_TICK        = 3'd4,
      ACT_OPEN        = 3'd5,
      ACT_CLOSE       = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic scan_step;
      logic shift_init;
      logic shift_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic       active;
      action_type action;
      logic       scan_more;
      logic       shift_more;
      logic       found;
      logic       rsp_busy;
   } sta_type;

endpackage

>>> hw/rtl/ttlst_ctrl.sv
// Sequencer for the subscription table: decode, table walk, shift-down and result commit.
module ttlst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ttlst_pkg::sta_type sta,
   output ttlst_pkg::cmd_type cmd
);

   ttlst_pkg::state_type state_ff, state_in;
   logic needs_walk;

   assign needs_walk = sta.active &&
                       (sta.action == ttlst_pkg::ACT_SUBSCRIBE ||
                        sta.action == ttlst_pkg::ACT_UNSUBSCRIBE ||
                        sta.action == ttlst_pkg::ACT_QUERY ||
                        sta.action == ttlst_pkg::ACT_SWEEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttlst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttlst_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ttlst_pkg::ST_DECODE;
         end
         ttlst_pkg::ST_DECODE: begin
            state_in = needs_walk ? ttlst_pkg::ST_SCAN : ttlst_pkg::ST_FINISH;
         end
         ttlst_pkg::ST_SCAN: begin
            if (!sta.scan_more) begin
               if (sta.action == ttlst_pkg::ACT_UNSUBSCRIBE && sta.found) begin
                  state_in = ttlst_pkg::ST_SHIFT;
               end else begin
                  state_in = ttlst_pkg::ST_FINISH;
               end
            end
         end
         ttlst_pkg::ST_SHIFT: begin
            if (!sta.shift_more) state_in = ttlst_pkg::ST_FINISH;
         end
         ttlst_pkg::ST_FINISH: begin
            if (!sta.rsp_busy) state_in = ttlst_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttlst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ttlst_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ttlst_pkg::ST_DECODE: begin
            cmd.mul = 1'b1;
         end
         ttlst_pkg::ST_SCAN: begin
            cmd.scan_step  = sta.scan_more;
            cmd.shift_init = !sta.scan_more &&
                             sta.action == ttlst_pkg::ACT_UNSUBSCRIBE && sta.found;
         end
         ttlst_pkg::ST_SHIFT: begin
            cmd.shift_step = sta.shift_more;
         end
         ttlst_pkg::ST_FINISH: begin
            cmd.commit = !sta.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/ttlst_dp.sv
// Datapath for the subscription table: entry store, timer, TTL multiply and result register.
module ttlst_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_tvalid,
   input  logic [15:0]        csr_tdata,
   input  logic [2:0]         req_tuser,
   input  logic [47:0]        req_tdata,
   input  ttlst_pkg::cmd_type cmd,
   output ttlst_pkg::sta_type sta,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata
);

   localparam int CW = ttlst_pkg::CNT_W;
   localparam int IW = ttlst_pkg::IDX_W;
   localparam int NE = ttlst_pkg::MAX_ENTRIES;

   logic [13:0]          tps_ff, tps_in;
   logic [31:0]          time_ff, time_in;
   logic                 active_ff, active_in;
   logic [CW-1:0]        used_ff, used_in;
   ttlst_pkg::action_type act_ff;
   logic [15:0]          grp_ff;
   logic [23:0]          ttl_ff;
   logic                 exists_ff;
   logic [31:0]          prod_ff;
   logic [37:0]          prod_full;
   logic [CW-1:0]        idx_ff, idx_in, idx_inc;
   logic                 found_ff, found_in;
   logic [IW-1:0]        k_ff, k_in;
   logic                 sub_ff, sub_in;
   logic [CW-1:0]        expc_ff, expc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic [15:0]          ent_group_ff   [NE];
   logic [31:0]          ent_expiry_ff  [NE];
   logic                 ent_expired_ff [NE];

   logic [IW-1:0]        rd_addr;
   logic [15:0]          rd_group;
   logic [31:0]          rd_expiry;
   logic                 rd_expired;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [15:0]          wr_group;
   logic [31:0]          wr_expiry;
   logic                 wr_expired;
   logic [31:0]          expiry_new;
   logic                 ok_c, sub_c;
   logic [CW-1:0]        expc_c;
   logic                 rd_match, rd_due;

   assign idx_inc    = idx_ff + CW'(1);
   assign rd_addr    = cmd.shift_step ? idx_inc[IW-1:0] : idx_ff[IW-1:0];
   assign rd_group   = ent_group_ff[rd_addr];
   assign rd_expiry  = ent_expiry_ff[rd_addr];
   assign rd_expired = ent_expired_ff[rd_addr];
   assign rd_match   = rd_group == grp_ff;
   assign rd_due     = !rd_expired && time_ff >= rd_expiry;
   assign prod_full  = ttl_ff * tps_ff;
   assign expiry_new = time_ff + prod_ff;

   always_comb begin
      tps_in       = tps_ff;
      time_in      = time_ff;
      active_in    = active_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      k_in         = k_ff;
      sub_in       = sub_ff;
      expc_in      = expc_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_group     = rd_group;
      wr_expiry    = rd_expiry;
      wr_expired   = rd_expired;
      ok_c         = 1'b0;
      sub_c        = 1'b0;
      expc_c       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_tvalid) tps_in = csr_tdata[13:0];

      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
         sub_in   = 1'b0;
         expc_in  = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_inc;
         if (rd_match && !found_ff) begin
            found_in = 1'b1;
            k_in     = idx_ff[IW-1:0];
         end
         if (rd_match && !rd_expired && time_ff < rd_expiry) sub_in = 1'b1;
         if (act_ff == ttlst_pkg::ACT_SWEEP && rd_due) begin
            wr_en      = 1'b1;
            wr_expired = 1'b1;
            expc_in    = expc_ff + CW'(1);
         end
      end

      if (cmd.shift_init) idx_in = CW'(k_ff);

      if (cmd.shift_step) begin
         wr_en  = 1'b1;
         idx_in = idx_inc;
      end

      if (cmd.commit) begin
         if (act_ff == ttlst_pkg::ACT_TICK) begin
            time_in = time_ff + 32'd1;
            ok_c    = 1'b1;
         end else if (act_ff == ttlst_pkg::ACT_OPEN) begin
            active_in = 1'b1;
            used_in   = '0;
            ok_c      = 1'b1;
         end else if (active_ff) begin
            case (act_ff)
               ttlst_pkg::ACT_SUBSCRIBE: begin
                  wr_group   = grp_ff;
                  wr_expiry  = expiry_new;
                  wr_expired = 1'b0;
                  if (exists_ff && found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = k_ff;
                     ok_c    = 1'b1;
                  end else if (exists_ff && used_ff < CW'(NE)) begin
                     wr_en   = 1'b1;
                     wr_addr = used_ff[IW-1:0];
                     used_in = used_ff + CW'(1);
                     ok_c    = 1'b1;
                  end
               end
               ttlst_pkg::ACT_UNSUBSCRIBE: begin
                  if (found_ff) begin
                     used_in = used_ff - CW'(1);
                     ok_c    = 1'b1;
                  end
               end
               ttlst_pkg::ACT_QUERY: begin
                  ok_c  = 1'b1;
                  sub_c = sub_ff;
               end
               ttlst_pkg::ACT_SWEEP: begin
                  ok_c   = 1'b1;
                  expc_c = expc_ff;
               end
               ttlst_pkg::ACT_CLOSE: begin
                  active_in = 1'b0;
                  used_in   = '0;
                  ok_c      = 1'b1;
               end
               default: begin
                  ok_c = 1'b0;
               end
            endcase
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, 4'(used_in), 4'(expc_c), sub_c, ok_c};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= ttlst_pkg::TPS_RESET;
         time_ff      <= '0;
         active_ff    <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         time_ff      <= time_in;
         active_ff    <= active_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      k_ff        <= k_in;
      sub_ff      <= sub_in;
      expc_ff     <= expc_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         act_ff    <= ttlst_pkg::action_type'(req_tuser);
         grp_ff    <= req_tdata[15:0];
         ttl_ff    <= req_tdata[39:16];
         exists_ff <= req_tdata[40];
      end
      if (cmd.mul) prod_ff <= prod_full[31:0];
      if (wr_en) begin
         ent_group_ff[wr_addr]   <= wr_group;
         ent_expiry_ff[wr_addr]  <= wr_expiry;
         ent_expired_ff[wr_addr] <= wr_expired;
      end
   end

   assign sta.active     = active_ff;
   assign sta.action     = act_ff;
   assign sta.scan_more  = idx_ff < used_ff;
   assign sta.shift_more = idx_inc < used_ff;
   assign sta.found      = found_ff;
   assign sta.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/ttl_subscription_table.sv
// Top level of the TTL subscription table: controller, datapath and checks.
// Keeps up to MAX_ENTRIES (8) event-group subscriptions with expiry times and handles one
// action per request transfer, answering with exactly one response transfer. One request is
// in flight at a time. Tick, open, close, the unused action code and any action on a closed
// table go from decode straight to the result commit; subscribe, query and sweep first walk
// the entries in use, and unsubscribe also shifts the later entries down after a match. The
// walk over the entry store goes one entry per cycle through its single read port. A
// finished response waits in an output register and holds the controller only when a second
// one is ready before the first is taken. The ticks-per-second register is written through
// the csr channel, which is always ready, and must only be written while idle.
module ttl_subscription_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata,   // [13:0] ticks_per_second
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] action
   input  logic [47:0] req_tdata,   // [15:0] group_id, [39:16] lifetime_sec, [40] group_exists
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] ok, [1] subscribed, [5:2] swept_count,
                                    // [9:6] entry_count
);

   ttlst_pkg::cmd_type cmd;
   ttlst_pkg::sta_type sta;

   assign csr_tready = 1'b1;

   ttlst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sta        (sta),
      .cmd        (cmd)
   );

   ttlst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tdata  (csr_tdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sta        (sta),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   a_sweep_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:2] != 4'd0 || rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("nonzero answer on a failed action");

   a_no_idle_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step || cmd.shift_step |-> sta.active)
      else $error("table walk on an inactive table");
`endif

endmodule
